>>> design/sob_pkg.sv
// ----------------------------------------------------------------------------
// sob_pkg
// Shared codes and types for the seat occupancy bitmap block
// ----------------------------------------------------------------------------
package sob_pkg;

    localparam logic [1:0] REQ_OCCUPY  = 2'd0;
    localparam logic [1:0] REQ_RELEASE = 2'd1;
    localparam logic [1:0] REQ_LIST    = 2'd2;

    localparam logic [1:0] KIND_MARK = 2'd0;
    localparam logic [1:0] KIND_FWD  = 2'd1;
    localparam logic [1:0] KIND_BWD  = 2'd2;
    localparam logic [1:0] KIND_END  = 2'd3;

    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_OCCUPIED = 2'd1;
    localparam logic [1:0] ST_FREE     = 2'd2;
    localparam logic [1:0] ST_RANGE    = 2'd3;

    localparam logic [5:0] LIST_COUNT_RESET = 6'd10;
    localparam logic [4:0] PASS_CAP         = 5'd31;

    typedef struct packed {
        logic set;
        logic clr;
    } t_map_cmd;

endpackage

>>> design/seat_occupancy_bitmap_top.sv
// ----------------------------------------------------------------------------
// seat_occupancy_bitmap_top
// Seat occupancy bitmap with occupy, release and free-seat listing
// ----------------------------------------------------------------------------
// One transaction is handled at a time; s_axis_tready is high only while idle.
// Occupy, release and unknown requests go from acceptance through the mark
// state to the status result. A list request walks the map one seat per cycle,
// while the output register can take each free seat found, through the
// single bit-test port: the forward pass and then the backward pass each
// examine seats until list_count (capped at 31) free seats are found or the
// map ends, and an end marker follows. Results leave through one output
// register. The map is cleared by a synchronous reset.
// ----------------------------------------------------------------------------
module seat_occupancy_bitmap_top #(
    parameter int CARS          = 3,
    parameter int SEATS_PER_CAR = 15
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [5:0] i_cfg_wdata,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // car_index[1:0], seat_index[5:2], zero[7:6]
    input  logic [1:0] s_axis_tuser,   // req_type[1:0]
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // status[1:0], car_out[3:2], seat_out[7:4]
    output logic [1:0] m_axis_tuser,   // kind[1:0]
    output logic       m_axis_tlast
);
    import sob_pkg::*;

    localparam int CW = (CARS > 1) ? $clog2(CARS) : 1;
    localparam int SW = (SEATS_PER_CAR > 1) ? $clog2(SEATS_PER_CAR) : 1;
    localparam logic [CW-1:0] CarLast  = CW'(CARS - 1);
    localparam logic [SW-1:0] SeatLast = SW'(SEATS_PER_CAR - 1);
    localparam logic [4:0] CarsLim  = 5'(CARS);
    localparam logic [6:0] SeatsLim = 7'(SEATS_PER_CAR);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MARK = 3'd1;
    localparam logic [2:0] S_FWD  = 3'd2;
    localparam logic [2:0] S_BWD  = 3'd3;
    localparam logic [2:0] S_END  = 3'd4;

    logic [2:0]    r_state, n_state;
    logic [1:0]    r_req;
    logic          r_oor;
    logic [CW-1:0] r_car, n_car;
    logic [SW-1:0] r_seat, n_seat;
    logic [4:0]    r_found, n_found;
    logic [5:0]    r_list_count;

    logic       r_out_valid;
    logic [1:0] r_out_kind, r_out_status, r_out_car;
    logic [3:0] r_out_seat;
    logic       r_out_last;

    logic       push;
    logic [1:0] push_kind, push_status;
    logic       push_last;
    logic       out_free;
    logic       occupied;
    t_map_cmd   map_cmd;
    logic [4:0] limit;
    logic       emit, at_last, at_first, pass_done;
    logic [7:0] car8;
    logic [7:0] seat8;
    logic [7:0] in_car8;
    logic [7:0] in_seat8;
    logic       in_oor;

    sob_map #(
        .CARS          (CARS),
        .SEATS_PER_CAR (SEATS_PER_CAR),
        .CW            (CW),
        .SW            (SW)
    ) u_map (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_car      (r_car),
        .i_seat     (r_seat),
        .i_cmd      (map_cmd),
        .o_occupied (occupied)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign out_free      = !r_out_valid || m_axis_tready;
    assign limit         = (r_list_count > 6'(PASS_CAP)) ? PASS_CAP : r_list_count[4:0];
    assign emit          = !occupied && (r_found != limit);
    assign at_last       = (r_car == CarLast) && (r_seat == SeatLast);
    assign at_first      = (r_car == '0) && (r_seat == '0);
    assign car8          = 8'(r_car);
    assign seat8         = 8'(r_seat);
    assign in_car8       = {6'd0, s_axis_tdata[1:0]};
    assign in_seat8      = {4'd0, s_axis_tdata[5:2]};
    assign in_oor        = ({3'd0, s_axis_tdata[1:0]} >= CarsLim)
                        || ({3'd0, s_axis_tdata[5:2]} >= SeatsLim);

    always_comb begin
        n_state     = r_state;
        n_car       = r_car;
        n_seat      = r_seat;
        n_found     = r_found;
        push        = 1'b0;
        push_kind   = KIND_MARK;
        push_status = ST_DONE;
        push_last   = 1'b0;
        map_cmd     = '0;
        pass_done   = at_last || (r_found == limit)
                   || (emit && (r_found + 5'd1 == limit));
        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_car   = in_car8[CW-1:0];
                    n_seat  = in_seat8[SW-1:0];
                    n_found = '0;
                    n_state = (s_axis_tuser == REQ_LIST) ? S_FWD : S_MARK;
                    if (s_axis_tuser == REQ_LIST) begin
                        n_car  = '0;
                        n_seat = '0;
                    end
                end
            end
            S_MARK: begin
                if (out_free) begin
                    push      = 1'b1;
                    push_kind = KIND_MARK;
                    push_last = 1'b1;
                    n_state   = S_IDLE;
                    case (r_req)
                        REQ_OCCUPY: begin
                            push_status = r_oor ? ST_RANGE
                                        : (occupied ? ST_OCCUPIED : ST_DONE);
                            map_cmd.set = !r_oor && !occupied;
                        end
                        REQ_RELEASE: begin
                            push_status = r_oor ? ST_RANGE
                                        : (occupied ? ST_DONE : ST_FREE);
                            map_cmd.clr = !r_oor && occupied;
                        end
                        default: begin
                            push_status = ST_RANGE;
                        end
                    endcase
                end
            end
            S_FWD: begin
                if (!emit || out_free) begin
                    push      = emit;
                    push_kind = KIND_FWD;
                    if (emit) begin
                        n_found = r_found + 5'd1;
                    end
                    if (pass_done) begin
                        n_state = S_BWD;
                        n_car   = CarLast;
                        n_seat  = SeatLast;
                        n_found = '0;
                    end else if (r_seat == SeatLast) begin
                        n_seat = '0;
                        n_car  = r_car + CW'(1);
                    end else begin
                        n_seat = r_seat + SW'(1);
                    end
                end
            end
            S_BWD: begin
                pass_done = at_first || (r_found == limit)
                         || (emit && (r_found + 5'd1 == limit));
                if (!emit || out_free) begin
                    push      = emit;
                    push_kind = KIND_BWD;
                    if (emit) begin
                        n_found = r_found + 5'd1;
                    end
                    if (pass_done) begin
                        n_state = S_END;
                    end else if (r_seat == '0) begin
                        n_seat = SeatLast;
                        n_car  = r_car - CW'(1);
                    end else begin
                        n_seat = r_seat - SW'(1);
                    end
                end
            end
            S_END: begin
                if (out_free) begin
                    push      = 1'b1;
                    push_kind = KIND_END;
                    push_last = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_list_count <= LIST_COUNT_RESET;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_list_count <= i_cfg_wdata;
            end
            if (push) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_car   <= n_car;
        r_seat  <= n_seat;
        r_found <= n_found;
        if (r_state == S_IDLE && s_axis_tvalid) begin
            r_req <= s_axis_tuser;
            r_oor <= in_oor;
        end
        if (push) begin
            r_out_kind   <= push_kind;
            r_out_status <= push_status;
            r_out_last   <= push_last;
            if (push_kind == KIND_FWD || push_kind == KIND_BWD) begin
                r_out_car  <= car8[1:0];
                r_out_seat <= seat8[3:0];
            end else begin
                r_out_car  <= '0;
                r_out_seat <= '0;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_seat, r_out_car, r_out_status};
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tlast  = r_out_last;

endmodule

>>> design/sob_map.sv
// ----------------------------------------------------------------------------
// sob_map
// Occupancy bitmap, one word per car, with a single seat test and update port
// ----------------------------------------------------------------------------
module sob_map #(
    parameter int CARS          = 3,
    parameter int SEATS_PER_CAR = 15,
    parameter int CW            = 2,
    parameter int SW            = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [CW-1:0]     i_car,
    input  logic [SW-1:0]     i_seat,
    input  sob_pkg::t_map_cmd i_cmd,
    output logic              o_occupied
);
    import sob_pkg::*;

    logic [SEATS_PER_CAR-1:0] r_map [CARS];

    assign o_occupied = r_map[i_car][i_seat];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CARS; c++) begin
                r_map[c] <= '0;
            end
        end else if (i_cmd.set) begin
            r_map[i_car][i_seat] <= 1'b1;
        end else if (i_cmd.clr) begin
            r_map[i_car][i_seat] <= 1'b0;
        end
    end

endmodule

>>> test/seat_occupancy_bitmap_top_tb.sv
// ----------------------------------------------------------------------------
// seat_occupancy_bitmap_top_tb
// Self-checking bench for the seat occupancy bitmap: a queue-fed stream driver
// sends occupy, release, list and malformed requests; a seat map kept in the
// bench predicts every status, list entry and end marker, and the monitor
// checks each output transaction in order across several list_count settings
// and several sender and receiver idling patterns
// ----------------------------------------------------------------------------
module seat_occupancy_bitmap_top_tb;
    import sob_pkg::*;

    localparam int N_CARS        = 3;
    localparam int N_SEATS       = 15;
    localparam int LIMIT_CYCLES  = 400000;
    localparam int SETTLE_CYCLES = 8;
    localparam logic [1:0] REQ_UNKNOWN = 2'd3;

    typedef struct packed {
        logic [1:0] req;
        logic [1:0] car;
        logic [3:0] seat;
    } seat_req_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [1:0] status;
        logic [1:0] car;
        logic [3:0] seat;
        logic       last;
    } seat_result_t;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_we = 1'b0;
    logic [5:0] i_cfg_wdata = '0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = '0;
    logic [1:0] s_axis_tuser = '0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;
    logic [1:0] m_axis_tuser;
    logic       m_axis_tlast;

    seat_req_t    request_queue[$];
    seat_result_t expected_results[$];
    logic [N_SEATS-1:0] seat_map [N_CARS];
    logic [5:0]   list_len = LIST_COUNT_RESET;
    int           requests_sent = 0;
    int           requests_taken = 0;
    int           error_count = 0;
    int           cycle_count = 0;
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;
    logic         req_taken = 1'b0;
    seat_req_t    next_req;
    seat_req_t    taken_req;
    seat_result_t want;

    seat_occupancy_bitmap_top #(
        .CARS          (N_CARS),
        .SEATS_PER_CAR (N_SEATS)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] exp_val);
        $display("mismatch on %s: got %0h expected %0h (cycle %0d)",
                 what, got, exp_val, cycle_count);
        error_count++;
    endtask

    task automatic push_result(input logic [1:0] kind, input logic [1:0] status,
                               input logic [1:0] car, input logic [3:0] seat,
                               input logic last);
        seat_result_t r;
        r.kind   = kind;
        r.status = status;
        r.car    = car;
        r.seat   = seat;
        r.last   = last;
        expected_results.push_back(r);
    endtask

    task automatic predict_request(input seat_req_t rq);
        logic [1:0] st;
        int cap;
        int found;
        if (rq.req == REQ_OCCUPY || rq.req == REQ_RELEASE) begin
            if (rq.car >= N_CARS || rq.seat >= N_SEATS) begin
                st = ST_RANGE;
            end else if (rq.req == REQ_OCCUPY) begin
                if (seat_map[rq.car][rq.seat]) begin
                    st = ST_OCCUPIED;
                end else begin
                    seat_map[rq.car][rq.seat] = 1'b1;
                    st = ST_DONE;
                end
            end else begin
                if (!seat_map[rq.car][rq.seat]) begin
                    st = ST_FREE;
                end else begin
                    seat_map[rq.car][rq.seat] = 1'b0;
                    st = ST_DONE;
                end
            end
            push_result(KIND_MARK, st, 2'd0, 4'd0, 1'b1);
        end else if (rq.req == REQ_LIST) begin
            cap = (list_len < PASS_CAP) ? int'(list_len) : int'(PASS_CAP);
            found = 0;
            for (int c = 0; c < N_CARS; c++) begin
                for (int s = 0; s < N_SEATS; s++) begin
                    if (found < cap && !seat_map[c][s]) begin
                        push_result(KIND_FWD, ST_DONE, 2'(c), 4'(s), 1'b0);
                        found++;
                    end
                end
            end
            found = 0;
            for (int c = N_CARS - 1; c >= 0; c--) begin
                for (int s = N_SEATS - 1; s >= 0; s--) begin
                    if (found < cap && !seat_map[c][s]) begin
                        push_result(KIND_BWD, ST_DONE, 2'(c), 4'(s), 1'b0);
                        found++;
                    end
                end
            end
            push_result(KIND_END, ST_DONE, 2'd0, 4'd0, 1'b1);
        end else begin
            push_result(KIND_MARK, ST_RANGE, 2'd0, 4'd0, 1'b1);
        end
    endtask

    task automatic queue_request(input logic [1:0] req, input logic [1:0] car,
                                 input logic [3:0] seat);
        seat_req_t rq;
        rq.req  = req;
        rq.car  = car;
        rq.seat = seat;
        request_queue.push_back(rq);
        requests_sent++;
    endtask

    task automatic queue_random_request(input int occupy_pct);
        int pick;
        logic [1:0] req;
        logic [1:0] car;
        logic [3:0] seat;
        pick = $urandom_range(0, 99);
        car  = 2'($urandom_range(0, N_CARS - 1));
        seat = 4'($urandom_range(0, N_SEATS - 1));
        if (pick < 8) begin
            // malformed: any request code, any index
            req  = 2'($urandom_range(0, 3));
            car  = 2'($urandom_range(0, 3));
            seat = 4'($urandom_range(0, 15));
        end else if (pick < 28) begin
            req = REQ_LIST;
        end else if ($urandom_range(0, 99) < occupy_pct) begin
            req = REQ_OCCUPY;
        end else begin
            req = REQ_RELEASE;
        end
        queue_request(req, car, seat);
    endtask

    task automatic wait_idle();
        while (!(requests_taken == requests_sent && expected_results.size() == 0))
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_list_count(input logic [5:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            m_axis_tready <= 1'b0;
        end else begin
            if (!s_axis_tvalid || req_taken) begin
                if (request_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    next_req = request_queue.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= next_req.req;
                    s_axis_tdata  <= {2'b00, next_req.seat, next_req.car};
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
            m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // monitor and prediction
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("seat_occupancy_bitmap_top verification failed");
            $finish;
        end else if (!i_rst_n) begin
            for (int c = 0; c < N_CARS; c++)
                seat_map[c] = '0;
            list_len  = LIST_COUNT_RESET;
            req_taken = 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected transaction", m_axis_tdata, 8'h00);
                end else begin
                    want = expected_results.pop_front();
                    if (m_axis_tuser !== want.kind)
                        report_mismatch("kind", 8'(m_axis_tuser), 8'(want.kind));
                    if (m_axis_tdata[1:0] !== want.status)
                        report_mismatch("status", 8'(m_axis_tdata[1:0]), 8'(want.status));
                    if (m_axis_tdata[3:2] !== want.car)
                        report_mismatch("car", 8'(m_axis_tdata[3:2]), 8'(want.car));
                    if (m_axis_tdata[7:4] !== want.seat)
                        report_mismatch("seat", 8'(m_axis_tdata[7:4]), 8'(want.seat));
                    if (m_axis_tlast !== want.last)
                        report_mismatch("last", 8'(m_axis_tlast), 8'(want.last));
                end
            end
            if (i_cfg_we)
                list_len = i_cfg_wdata;
            req_taken = s_axis_tvalid && s_axis_tready;
            if (req_taken) begin
                taken_req.req  = s_axis_tuser;
                taken_req.car  = s_axis_tdata[1:0];
                taken_req.seat = s_axis_tdata[5:2];
                predict_request(taken_req);
                requests_taken++;
            end
        end
    end

    initial begin
        int cfg_plan [5];
        int occupy_plan [5];
        cfg_plan    = '{45, 5, 31, 1, 18};
        occupy_plan = '{65, 45, 75, 35, 55};

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed, reset list_count with an empty map
        queue_request(REQ_LIST,    2'd0, 4'd0);
        queue_request(REQ_OCCUPY,  2'd0, 4'd0);
        queue_request(REQ_OCCUPY,  2'd0, 4'd0);
        queue_request(REQ_RELEASE, 2'd0, 4'd0);
        queue_request(REQ_RELEASE, 2'd0, 4'd0);
        queue_request(REQ_OCCUPY,  2'd3, 4'd0);
        queue_request(REQ_OCCUPY,  2'd0, 4'd15);
        queue_request(REQ_RELEASE, 2'd3, 4'd15);
        queue_request(REQ_RELEASE, 2'd1, 4'd15);
        queue_request(REQ_UNKNOWN, 2'd3, 4'd15);
        queue_request(REQ_UNKNOWN, 2'd0, 4'd0);
        queue_request(REQ_OCCUPY,  2'd2, 4'd14);
        queue_request(REQ_OCCUPY,  2'd2, 4'd0);
        queue_request(REQ_OCCUPY,  2'd0, 4'd1);
        queue_request(REQ_OCCUPY,  2'd1, 4'd7);
        queue_request(REQ_LIST,    2'd0, 4'd0);
        wait_idle();

        // zero-length listing gives only the end marker
        write_list_count(6'd0);
        queue_request(REQ_LIST,    2'd0, 4'd0);
        queue_request(REQ_RELEASE, 2'd1, 4'd7);
        queue_request(REQ_LIST,    2'd0, 4'd0);
        wait_idle();

        for (int k = 0; k < 5; k++) begin
            write_list_count(6'(cfg_plan[k]));
            case (k % 4)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 75;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 75;
                end
                default: begin
                    send_idle_pct  = 9;
                    recv_stall_pct = 9;
                end
            endcase
            for (int n = 0; n < 58; n++)
                queue_random_request(occupy_plan[k]);
            wait_idle();
        end

        if (error_count == 0) begin
            $display("seat_occupancy_bitmap_top verification clean");
        end else begin
            $display("seat_occupancy_bitmap_top verification failed");
        end
        $finish;
    end

endmodule
